// ----- rtl/core/mbce_pkg.sv -----
package mbce_pkg;

   localparam int DIM_W         = 10;
   localparam int COLOUR_W      = 16;
   localparam int BYTE_W        = 8;
   localparam int MAX_DIM_DEF   = 512;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FORE_COLOUR  = 2'd2,
      CSR_BACK_COLOUR  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [COLOUR_W-1:0] fore_colour;
      logic [COLOUR_W-1:0] back_colour;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] bitmap_byte;
      logic              image_start;
   } queue_entry_type;

   // head of queue as seen by the back end
   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

endpackage

// ----- rtl/core/mbce_if.sv -----
interface mbce_req_if
   import mbce_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] bitmap_byte;
   logic              image_start;

   modport source (output valid, output bitmap_byte, output image_start, input ready);
   modport sink   (input valid, input bitmap_byte, input image_start, output ready);
endinterface

interface mbce_rsp_if
   import mbce_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] pixel_colour;
   logic                row_end;
   logic                image_end;
   logic                run_last;

   modport source (output valid, output pixel_colour, output row_end, output image_end,
                   output run_last, input ready);
   modport sink   (input valid, input pixel_colour, input row_end, input image_end,
                   input run_last, output ready);
endinterface

interface mbce_csr_if
   import mbce_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/mbce_front.sv -----
module mbce_front
   import mbce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   mbce_req_if.sink        req_bus,
   output queue_head_type  head,
   input  logic            pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type      mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   logic                 do_pop;

   assign req_bus.ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign do_pop        = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = mem[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push   ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= '{bitmap_byte: req_bus.bitmap_byte,
                             image_start: req_bus.image_start};
      end
   end

endmodule

// ----- rtl/core/mbce_back.sv -----
module mbce_back
   import mbce_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  queue_head_type  head,
   output logic            pop,
   mbce_rsp_if.source      rsp_bus
);

   localparam int               CLAMP   = (MAX_DIM > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1
                                                                     : MAX_DIM;
   localparam logic [DIM_W-1:0] CLAMP_V = DIM_W'(CLAMP);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end
      if (v > CLAMP_V) begin
         return CLAMP_V;
      end
      return v;
   endfunction

   logic [DIM_W-1:0]    col_ff, col_in;
   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic                active_ff, active_in;
   logic                busy_ff, busy_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [2:0]          idx_ff, idx_in;

   logic                out_valid_ff, out_valid_in;
   logic [COLOUR_W-1:0] out_pixel_ff, out_pixel_in;
   logic                out_row_ff, out_row_in;
   logic                out_img_ff, out_img_in;
   logic                out_last_ff, out_last_in;

   logic                advance;
   logic                emit;
   logic                last_px;
   logic [DIM_W-1:0]    col_inc;
   logic                row_done;
   logic [DIM_W-1:0]    width_eff;

   assign width_eff = eff_dim(cfg.image_width);
   assign advance   = !out_valid_ff || rsp_bus.ready;
   assign emit      = busy_ff && advance;
   assign col_inc   = col_ff + DIM_W'(1);
   assign row_done  = (col_inc >= width_eff);
   assign last_px   = row_done || (idx_ff == 3'd7);
   assign pop       = head.valid && (!busy_ff || (emit && last_px));

   always_comb begin
      col_in       = col_ff;
      rows_in      = rows_ff;
      active_in    = active_ff;
      busy_in      = busy_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      out_pixel_in = out_pixel_ff;
      out_row_in   = out_row_ff;
      out_img_in   = out_img_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;

      // one pixel per free output slot, MSB first
      if (emit) begin
         out_valid_in = 1'b1;
         out_pixel_in = shift_ff[BYTE_W-1] ? cfg.back_colour : cfg.fore_colour;
         out_row_in   = row_done;
         out_img_in   = 1'b0;
         out_last_in  = last_px;
         shift_in     = {shift_ff[BYTE_W-2:0], 1'b0};
         idx_in       = idx_ff + 3'd1;
         col_in       = col_inc;
         if (row_done) begin
            col_in  = '0;
            rows_in = rows_ff - DIM_W'(1);
            if (rows_in == '0) begin
               out_img_in = 1'b1;
               active_in  = 1'b0;
            end
         end
         if (last_px) begin
            busy_in = 1'b0;
         end
      end

      // next byte; start overrides whatever the last pixel left
      if (pop) begin
         if (head.entry.image_start) begin
            col_in    = '0;
            rows_in   = eff_dim(cfg.image_height);
            active_in = 1'b1;
         end
         busy_in  = active_in;
         shift_in = head.entry.bitmap_byte;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         rows_ff      <= '0;
         active_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         rows_ff      <= rows_in;
         active_ff    <= active_in;
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      out_pixel_ff <= out_pixel_in;
      out_row_ff   <= out_row_in;
      out_img_ff   <= out_img_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pixel_colour = out_pixel_ff;
   assign rsp_bus.row_end      = out_row_ff;
   assign rsp_bus.image_end    = out_img_ff;
   assign rsp_bus.run_last     = out_last_ff;

endmodule

// ----- rtl/core/mono_bitmap_colour_expander.sv -----
// The first pixel of a byte passes through the queue, the back end's shift register and the output register.
// Throughput: one pixel per cycle out of the output register while the output is ready and bytes are
//   queued; a byte yields 1..8 pixels (fewer where its row ends), and a byte may yield none.
// Input beats are taken while the 4-entry queue has room, independent of the output.
// Reset (synchronous, active high): queue empty, image idle, width/height 1, colours 0.
module mono_bitmap_colour_expander
   import mbce_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   mbce_req_if.sink    req_bus,
   mbce_rsp_if.source  rsp_bus,
   mbce_csr_if.sink    csr_bus
);

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;
   logic           csr_write;

   // config registers: always ready; must be written by the user only while the block is idle (unchecked)
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_bus.data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_bus.data[DIM_W-1:0];
            CSR_FORE_COLOUR:  cfg_in.fore_colour  = csr_bus.data[COLOUR_W-1:0];
            CSR_BACK_COLOUR:  cfg_in.back_colour  = csr_bus.data[COLOUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{image_width:  WIDTH_RESET,
                     image_height: HEIGHT_RESET,
                     fore_colour:  '0,
                     back_colour:  '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: takes byte beats into a short queue
   mbce_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   // back end: tracks row/image position, expands bits into pixel beats
   mbce_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
